@@ design/sequenced_event_ring_log_defines.svh @@
// ----------------------------------------------------------------------------
// Sequenced event ring log: assertion macros
// Shared shorthand for concurrent checks on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_EVENT_RING_LOG_DEFINES_SVH
`define SEQUENCED_EVENT_RING_LOG_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SERL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SERL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/serl_pkg.sv @@
// ----------------------------------------------------------------------------
// Sequenced event ring log package
// Command codes, transfer structs and small helpers shared by the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package serl_pkg;

  localparam int unsigned SEQ_BITS     = 64;
  localparam int unsigned OUT_PAY_BITS = 32;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [5:0] MAX_LIMIT = 6'd32;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [31:0]         payload;
    logic [SEQ_BITS-1:0] cursor;
    logic [5:0]          limit;
  } in_item_t;

  typedef struct packed {
    logic                    has_entry;
    logic [SEQ_BITS-1:0]     entry_seq;
    logic [OUT_PAY_BITS-1:0] entry_payload;
    logic [SEQ_BITS-1:0]     latest;
    logic                    last;
  } out_item_t;

  // The latest assigned number is one below the next one, or zero when the
  // counter sits at zero or one.
  function automatic logic [SEQ_BITS-1:0] latest_of(input logic [SEQ_BITS-1:0] seq_next);
    logic [SEQ_BITS-1:0] res;
    res = (seq_next <= SEQ_BITS'(1)) ? '0 : seq_next - SEQ_BITS'(1);
    return res;
  endfunction

  function automatic out_item_t make_result(input logic                    has,
                                            input logic [SEQ_BITS-1:0]     seq,
                                            input logic [OUT_PAY_BITS-1:0] pay,
                                            input logic [SEQ_BITS-1:0]     latest,
                                            input logic                    last);
    out_item_t res;
    res.has_entry     = has;
    res.entry_seq     = seq;
    res.entry_payload = pay;
    res.latest        = latest;
    res.last          = last;
    return res;
  endfunction

endpackage

@@ design/sequenced_event_ring_log.sv @@
// ----------------------------------------------------------------------------
// Sequenced event ring log
// Ring of stamped events with push, clear and cursor-filtered ordered reads.
// ----------------------------------------------------------------------------
//   Channel   Ports                       Handshake
//   input     start, busy, in_item        transfer when start && !busy
//   result    out_valid, out_item         one-cycle strobe, always taken
//
// Push, clear and the unused code give their single result in the cycle after
// the transfer, and the block is ready for the next item in that same cycle.
// A read with entries held and a nonzero limit walks the entries one per cycle
// through the memory read port, and is busy until the walk ends or the limit
// of matches is met; results spread over the walk, the final one as busy falls.
// Reset (synchronous, active low) empties the log; no clearing pass is needed.
// The receiver cannot stall, so results never wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sequenced_event_ring_log_defines.svh"

module sequenced_event_ring_log #(
  parameter int unsigned DEPTH        = 32,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  serl_pkg::in_item_t  in_item,
  output logic                out_valid,
  output serl_pkg::out_item_t out_item
);

  import serl_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = SEQ_BITS + PAYLOAD_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           wp_r, wp_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [SEQ_BITS-1:0]     seq_next_r, seq_next_nxt;
  logic [SEQ_BITS-1:0]     cursor_r, cursor_nxt;
  logic [5:0]              limit_r, limit_nxt;
  logic [CW-1:0]           scan_cnt_r, scan_cnt_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;
  logic [CW-1:0]           issued_r, issued_nxt;
  logic [CW-1:0]           rcvd_r, rcvd_nxt;
  logic                    dv_r, dv_nxt;
  logic [5:0]              match_r, match_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic [SEQ_BITS-1:0]     pend_seq_r, pend_seq_nxt;
  logic [PAYLOAD_BITS-1:0] pend_pay_r, pend_pay_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  logic                    accept;
  logic                    wr_en;
  logic                    rd_en;
  logic [EW-1:0]           wr_data;
  logic [EW-1:0]           rd_data;
  logic [SEQ_BITS-1:0]     rd_seq;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    hit;
  logic                    done;
  logic [5:0]              lim;
  logic [SEQ_BITS-1:0]     latest_cur;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign wr_data    = {seq_next_r, PAYLOAD_BITS'(in_item.payload)};
  assign rd_seq     = rd_data[EW-1 -: SEQ_BITS];
  assign rd_pay     = rd_data[PAYLOAD_BITS-1:0];
  assign hit        = (rd_seq > cursor_r);
  assign latest_cur = latest_of(seq_next_r);
  assign lim        = (in_item.limit > MAX_LIMIT) ? MAX_LIMIT : in_item.limit;

  serl_ram #(
    .DEPTH(DEPTH),
    .WIDTH(EW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wp_r),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(addr_r),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    seq_next_nxt  = seq_next_r;
    cursor_nxt    = cursor_r;
    limit_nxt     = limit_r;
    scan_cnt_nxt  = scan_cnt_r;
    addr_nxt      = addr_r;
    issued_nxt    = issued_r;
    rcvd_nxt      = rcvd_r;
    dv_nxt        = dv_r;
    match_nxt     = match_r;
    pend_v_nxt    = pend_v_r;
    pend_seq_nxt  = pend_seq_r;
    pend_pay_nxt  = pend_pay_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    done          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (in_item.cmd)
            CMD_PUSH: begin
              wr_en        = 1'b1;
              seq_next_nxt = seq_next_r + SEQ_BITS'(1);
              wp_nxt       = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
              if (count_r < CW'(DEPTH)) begin
                count_nxt = count_r + CW'(1);
              end
              out_item_nxt = make_result(1'b0, '0, '0, latest_of(seq_next_nxt), 1'b1);
            end
            CMD_CLEAR: begin
              wp_nxt       = '0;
              count_nxt    = '0;
              seq_next_nxt = SEQ_BITS'(1);
              out_item_nxt = make_result(1'b0, '0, '0, latest_of(seq_next_nxt), 1'b1);
            end
            CMD_READ: begin
              if ((count_r == '0) || (lim == '0)) begin
                out_item_nxt = make_result(1'b0, '0, '0, latest_cur, 1'b1);
              end else begin
                // Results start coming out of the walk, not here.
                out_valid_nxt = 1'b0;
                cursor_nxt    = in_item.cursor;
                limit_nxt     = lim;
                scan_cnt_nxt  = count_r;
                // A ring that has not wrapped yet starts at slot zero.
                addr_nxt      = (count_r < CW'(DEPTH)) ? '0 : wp_r;
                issued_nxt    = '0;
                rcvd_nxt      = '0;
                dv_nxt        = 1'b0;
                match_nxt     = '0;
                pend_v_nxt    = 1'b0;
                state_nxt     = ST_SCAN;
              end
            end
            default: begin
              out_item_nxt = make_result(1'b0, '0, '0, latest_cur, 1'b1);
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (issued_r != scan_cnt_r) begin
          rd_en      = 1'b1;
          addr_nxt   = (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + AW'(1);
          issued_nxt = issued_r + CW'(1);
          dv_nxt     = 1'b1;
        end else begin
          dv_nxt = 1'b0;
        end

        if (dv_r) begin
          rcvd_nxt = rcvd_r + CW'(1);
          // A match is held back until the next one arrives so the final one can carry last.
          if (hit) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = make_result(1'b1, pend_seq_r, OUT_PAY_BITS'(pend_pay_r),
                                          latest_cur, 1'b0);
            end
            pend_v_nxt   = 1'b1;
            pend_seq_nxt = rd_seq;
            pend_pay_nxt = rd_pay;
            match_nxt    = match_r + 6'd1;
          end
          done = (rcvd_nxt == scan_cnt_r) || (hit && (match_nxt == limit_r));
          if (done) begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (pend_v_r) begin
          out_item_nxt = make_result(1'b1, pend_seq_r, OUT_PAY_BITS'(pend_pay_r),
                                     latest_cur, 1'b1);
        end else begin
          out_item_nxt = make_result(1'b0, '0, '0, latest_cur, 1'b1);
        end
        pend_v_nxt = 1'b0;
        dv_nxt     = 1'b0;
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      count_r     <= '0;
      seq_next_r  <= SEQ_BITS'(1);
      dv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      match_r     <= '0;
      issued_r    <= '0;
      rcvd_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      seq_next_r  <= seq_next_nxt;
      dv_r        <= dv_nxt;
      pend_v_r    <= pend_v_nxt;
      match_r     <= match_nxt;
      issued_r    <= issued_nxt;
      rcvd_r      <= rcvd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cursor_r   <= cursor_nxt;
    limit_r    <= limit_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    addr_r     <= addr_nxt;
    pend_seq_r <= pend_seq_nxt;
    pend_pay_r <= pend_pay_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SERL_ASSERT_NEXT(a_push_one_result,
                    accept && (in_item.cmd == CMD_PUSH),
                    out_valid && out_item.last && !out_item.has_entry,
                    "push did not give one final empty result")
  `SERL_ASSERT_SAME(a_empty_is_last,
                    out_valid && !out_item.has_entry,
                    out_item.last && (out_item.entry_seq == '0) && (out_item.entry_payload == '0),
                    "empty result is not a final zeroed result")
  `SERL_ASSERT_SAME(a_mid_has_entry,
                    out_valid && !out_item.last,
                    out_item.has_entry && (state_r == ST_SCAN || state_r == ST_FLUSH),
                    "non-final result outside a read walk")
  `SERL_ASSERT_SAME(a_count_bound,
                    1'b1,
                    (count_r <= CW'(DEPTH)) && (match_r <= MAX_LIMIT),
                    "entry or match count out of range")

endmodule

@@ design/serl_ram.sv @@
// ----------------------------------------------------------------------------
// Sequenced event ring log: entry memory
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serl_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ bench/serl_log_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event ring log checker
// Watches both channels of the ring log and keeps a shadow copy of the ring.
// It predicts the results of every accepted command and compares each result
// strobe, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module serl_log_checker #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  serl_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  serl_pkg::out_item_t out_item,
  output int unsigned         fail_count,
  output int unsigned         outstanding
);
  import serl_pkg::*;

  logic [31:0]         ring_payload [DEPTH];
  logic [SEQ_BITS-1:0] ring_seq     [DEPTH];
  int unsigned         wr_slot;
  int unsigned         held_count;
  logic [SEQ_BITS-1:0] shadow_seq;
  out_item_t           awaited [$];
  int unsigned         mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [SEQ_BITS-1:0] newest_seq();
    return (shadow_seq <= 1) ? '0 : shadow_seq - 1;
  endfunction

  // Single closing result of a push, a clear, the spare code or an empty read.
  function automatic out_item_t closing_result();
    out_item_t res;
    res        = '0;
    res.latest = newest_seq();
    res.last   = 1'b1;
    return res;
  endfunction

  task automatic predict_log_response(input in_item_t item);
    int unsigned cap;
    int unsigned oldest;
    int unsigned slot;
    int unsigned found;
    int unsigned i;
    out_item_t   held;
    cap   = (item.limit > MAX_LIMIT) ? MAX_LIMIT : item.limit;
    found = 0;
    held  = '0;
    case (item.cmd)
      CMD_PUSH: begin
        ring_payload[wr_slot] = item.payload;
        ring_seq[wr_slot]     = shadow_seq;
        shadow_seq            = shadow_seq + 1;
        wr_slot               = (wr_slot + 1) % DEPTH;
        if (held_count < DEPTH) held_count++;
        awaited.insert(awaited.size(), closing_result());
      end
      CMD_CLEAR: begin
        wr_slot    = 0;
        held_count = 0;
        shadow_seq = 1;
        awaited.insert(awaited.size(), closing_result());
      end
      CMD_READ: begin
        // Once the ring has wrapped, the oldest entry sits at the write slot.
        oldest = (held_count < DEPTH) ? 0 : wr_slot;
        for (i = 0; i < held_count && found < cap; i++) begin
          slot = (oldest + i) % DEPTH;
          if (ring_seq[slot] > item.cursor) begin
            if (found > 0) awaited.insert(awaited.size(), held);
            held               = '0;
            held.has_entry     = 1'b1;
            held.entry_seq     = ring_seq[slot];
            held.entry_payload = ring_payload[slot];
            held.latest        = newest_seq();
            found++;
          end
        end
        if (found == 0) begin
          awaited.insert(awaited.size(), closing_result());
        end else begin
          held.last = 1'b1;
          awaited.insert(awaited.size(), held);
        end
      end
      CMD_NOP: begin
        awaited.insert(awaited.size(), closing_result());
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      wr_slot    = 0;
      held_count = 0;
      shadow_seq = 1;
      awaited.delete();
    end else begin
      if (out_valid) begin
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: unexpected result has=%0b seq=%0h pay=%0h latest=%0h last=%0b",
                     out_item.has_entry, out_item.entry_seq, out_item.entry_payload,
                     out_item.latest, out_item.last);
        end else begin
          want = awaited.pop_front();
          if (out_item.has_entry !== want.has_entry || out_item.entry_seq !== want.entry_seq ||
              out_item.entry_payload !== want.entry_payload ||
              out_item.latest !== want.latest || out_item.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("checker: mismatch expected has=%0b seq=%0h pay=%0h latest=%0h last=%0b",
                       want.has_entry, want.entry_seq, want.entry_payload,
                       want.latest, want.last);
              $display("checker:          actual   has=%0b seq=%0h pay=%0h latest=%0h last=%0b",
                       out_item.has_entry, out_item.entry_seq, out_item.entry_payload,
                       out_item.latest, out_item.last);
            end
          end
        end
      end
      // Results of a command only appear after its transfer, so checking first is safe.
      if (start && !busy) predict_log_response(in_item);
    end
    outstanding <= awaited.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event ring log testbench
// Drives a directed set of pushes, reads, clears and spare-code commands, then
// a few hundred random commands with bursts of idle time, and leaves all
// result checking to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb;
  import serl_pkg::*;

  localparam int unsigned DEPTH         = 32;
  localparam int unsigned RANDOM_ITEMS  = 300;
  localparam int unsigned CALM_ITEMS    = 50;
  localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  in_item_t            in_item   = '0;
  logic                busy;
  logic                out_valid;
  out_item_t           out_item;
  int unsigned         fail_count;
  int unsigned         outstanding;
  int unsigned         cycle_count = 0;
  // Number of pushes since the last clear; used only to aim read cursors.
  logic [SEQ_BITS-1:0] seq_hint    = '0;

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  sequenced_event_ring_log #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (32)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  serl_log_checker #(
    .DEPTH (DEPTH)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  function automatic in_item_t log_cmd(input logic [1:0]          cmd,
                                       input logic [31:0]         payload,
                                       input logic [SEQ_BITS-1:0] cursor,
                                       input logic [5:0]          limit);
    in_item_t item;
    item.cmd     = cmd;
    item.payload = payload;
    item.cursor  = cursor;
    item.limit   = limit;
    return item;
  endfunction

  function automatic in_item_t random_cmd();
    int unsigned         pick;
    int unsigned         back;
    logic [1:0]          cmd;
    logic [SEQ_BITS-1:0] cursor;
    logic [5:0]          limit;
    pick = $urandom_range(0, 99);
    if (pick < 56)      cmd = CMD_PUSH;
    else if (pick < 95) cmd = CMD_READ;
    else if (pick < 97) cmd = CMD_CLEAR;
    else                cmd = CMD_NOP;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      cursor = '0;
    end else if (pick < 15) begin
      cursor = '1;
    end else if (pick < 25) begin
      cursor = {$urandom, $urandom};
    end else begin
      back   = $urandom_range(0, 40);
      cursor = (seq_hint > back) ? seq_hint - back : '0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10)      limit = '0;
    else if (pick < 25) limit = 6'($urandom_range(33, 63));
    else                limit = 6'($urandom_range(1, 32));
    return log_cmd(cmd, $urandom, cursor, limit);
  endfunction

  // Holds start high until the block takes the command; start is left high.
  task automatic issue(input in_item_t item);
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    if (item.cmd == CMD_PUSH)       seq_hint = seq_hint + 1;
    else if (item.cmd == CMD_CLEAR) seq_hint = '0;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned k;
    bit          calm;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reads and the spare code on an empty log.
    issue(log_cmd(CMD_READ, 32'h0, '0, 6'd32));
    issue(log_cmd(CMD_READ, '1, '0, 6'd0));
    issue(log_cmd(CMD_NOP, '1, '1, '1));
    // Payload extremes, then reads across limit and cursor corners.
    issue(log_cmd(CMD_PUSH, 32'h0000_0000, '1, 6'd0));
    issue(log_cmd(CMD_PUSH, 32'hFFFF_FFFF, '0, '1));
    issue(log_cmd(CMD_PUSH, 32'hA5A5_5A5A, '0, 6'd5));
    issue(log_cmd(CMD_PUSH, $urandom, {$urandom, $urandom}, 6'd17));
    issue(log_cmd(CMD_READ, $urandom, '0, 6'd32));
    issue(log_cmd(CMD_READ, $urandom, '0, 6'd0));
    issue(log_cmd(CMD_READ, $urandom, '0, 6'd63));
    issue(log_cmd(CMD_READ, $urandom, '0, 6'd1));
    issue(log_cmd(CMD_READ, $urandom, 64'd2, 6'd32));
    issue(log_cmd(CMD_READ, $urandom, '1, 6'd32));
    issue(log_cmd(CMD_READ, $urandom, 64'd4, 6'd33));
    issue(log_cmd(CMD_NOP, $urandom, '0, 6'd32));
    issue(log_cmd(CMD_READ, $urandom, '0, 6'd32));
    // Clear restarts numbering at one.
    issue(log_cmd(CMD_CLEAR, $urandom, '1, '1));
    issue(log_cmd(CMD_READ, $urandom, '0, 6'd32));
    issue(log_cmd(CMD_PUSH, $urandom, '0, 6'd0));
    issue(log_cmd(CMD_READ, $urandom, '0, 6'd33));
    issue(log_cmd(CMD_CLEAR, '0, '0, '0));
    drain();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 25 == 0) calm = ($urandom_range(0, 2) == 0);
      issue(random_cmd());
      // Hold off midway until the log has answered everything sent so far.
      if (k == RANDOM_ITEMS / 2) begin
        drain();
      end else if (k < RANDOM_ITEMS - CALM_ITEMS && !calm && $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/serl_pkg.sv
design/serl_ram.sv
design/sequenced_event_ring_log.sv
bench/serl_log_checker.sv
bench/tb.sv
